### src/cpss_pkg.sv
`timescale 1ns / 1ps

package cpss_pkg;

    localparam logic [16:0] FULL_SCALE = 17'd65536;
    localparam logic [31:0] STOP_INFINITE = 32'hFFFF_FFFF;

    // cause codes
    localparam logic [2:0] CAUSE_CLEAR    = 3'd0;
    localparam logic [2:0] CAUSE_CONTACT  = 3'd1;
    localparam logic [2:0] CAUSE_SLOWDOWN = 3'd2;
    localparam logic [2:0] CAUSE_TOOCLOSE = 3'd3;
    localparam logic [2:0] CAUSE_NOSTOP   = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_SCENE_THR = 3'd1;
    localparam logic [2:0] REG_SELF_THR  = 3'd2;
    localparam logic [2:0] REG_SCENE_GN  = 3'd3;
    localparam logic [2:0] REG_SELF_GN   = 3'd4;
    localparam logic [2:0] REG_MIN_DIST  = 3'd5;
    localparam logic [2:0] REG_SAFETY    = 3'd6;
    localparam logic [2:0] REG_PERIOD    = 3'd7;

    // dividend bits of the time-to-impact quotient
    localparam int DIV_STEPS = 47;
    localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

    typedef struct packed {
        logic        check_mode;
        logic [20:0] scene_threshold;
        logic [20:0] self_threshold;
        logic [31:0] scene_gain;
        logic [31:0] self_gain;
        logic [20:0] min_allowed_distance;
        logic [15:0] safety_factor;
        logic [16:0] check_period;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_POS,
        OP_RDHI,
        OP_RDLO,
        OP_INTERP,
        OP_FIN,
        OP_STOP,
        OP_DIV,
        OP_DECIDE,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ch;
    } cmd_t;

    typedef struct packed {
        logic contact;
        logic mode;
        logic need_div;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

### src/cpss_if.sv
`timescale 1ns / 1ps

interface cpss_in_if;
    logic               valid;
    logic               ready;
    logic               in_collision;
    logic signed [21:0] scene_distance;
    logic signed [21:0] self_distance;
    logic [31:0]        stop_time;

    modport source (output valid, in_collision, scene_distance, self_distance, stop_time,
                    input ready);
    modport sink (input valid, in_collision, scene_distance, self_distance, stop_time,
                  output ready);
endinterface

interface cpss_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] speed_scale;
    logic [2:0]  cause;

    modport source (output valid, speed_scale, cause, input ready);
    modport sink (input valid, speed_scale, cause, output ready);
endinterface

### src/collision_proximity_speed_scaler_unit.sv
`timescale 1ns / 1ps
// contact words go from dispatch straight to the result; threshold mode runs
// multiply, position, two table reads, interpolate and finish per channel, scene
// then self; stop mode runs stop and decide, then the 47-step divider when the
// approach test needs it; one word at a time, held up while the output stalls
// reset: rst_n asynchronous active low; config registers return to defaults,
// the previous minimum distance clears to zero, no result pending
module collision_proximity_speed_scaler_unit
#(
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cpss_in_if.sink     in_ch,
    cpss_out_if.source  out_ch
);

    cpss_pkg::cfg_t    cfg;
    cpss_pkg::cmd_t    cmd;
    cpss_pkg::status_t status;

    cpss_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cpss_dp #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .in_collision   (in_ch.in_collision),
        .scene_distance (in_ch.scene_distance),
        .self_distance  (in_ch.self_distance),
        .stop_time      (in_ch.stop_time),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .speed_scale    (out_ch.speed_scale),
        .cause          (out_ch.cause)
    );

endmodule

### src/cpss_regs.sv
`timescale 1ns / 1ps

module cpss_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cpss_pkg::cfg_t     cfg
);

    cpss_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_mode           <= 1'b0;
            cfg_reg.scene_threshold      <= 21'd65536;
            cfg_reg.self_threshold       <= 21'd65536;
            cfg_reg.scene_gain           <= 32'd452707;
            cfg_reg.self_gain            <= 32'd452707;
            cfg_reg.min_allowed_distance <= 21'd0;
            cfg_reg.safety_factor        <= 16'd256;
            cfg_reg.check_period         <= 17'd655;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                cpss_pkg::REG_MODE:      cfg_reg.check_mode           <= pwdata[0];
                cpss_pkg::REG_SCENE_THR: cfg_reg.scene_threshold      <= pwdata[20:0];
                cpss_pkg::REG_SELF_THR:  cfg_reg.self_threshold       <= pwdata[20:0];
                cpss_pkg::REG_SCENE_GN:  cfg_reg.scene_gain           <= pwdata;
                cpss_pkg::REG_SELF_GN:   cfg_reg.self_gain            <= pwdata;
                cpss_pkg::REG_MIN_DIST:  cfg_reg.min_allowed_distance <= pwdata[20:0];
                cpss_pkg::REG_SAFETY:    cfg_reg.safety_factor        <= pwdata[15:0];
                cpss_pkg::REG_PERIOD:    cfg_reg.check_period         <= pwdata[16:0];
                default:                 ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (paddr[4:2])
            cpss_pkg::REG_MODE:      prdata = {31'd0, cfg_reg.check_mode};
            cpss_pkg::REG_SCENE_THR: prdata = {11'd0, cfg_reg.scene_threshold};
            cpss_pkg::REG_SELF_THR:  prdata = {11'd0, cfg_reg.self_threshold};
            cpss_pkg::REG_SCENE_GN:  prdata = cfg_reg.scene_gain;
            cpss_pkg::REG_SELF_GN:   prdata = cfg_reg.self_gain;
            cpss_pkg::REG_MIN_DIST:  prdata = {11'd0, cfg_reg.min_allowed_distance};
            cpss_pkg::REG_SAFETY:    prdata = {16'd0, cfg_reg.safety_factor};
            cpss_pkg::REG_PERIOD:    prdata = {15'd0, cfg_reg.check_period};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

### src/cpss_ctrl.sv
`timescale 1ns / 1ps

module cpss_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpss_pkg::status_t   status,
    output cpss_pkg::cmd_t      cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DISPATCH = 12'b0000_0000_0010,
        S_MUL      = 12'b0000_0000_0100,
        S_POS      = 12'b0000_0000_1000,
        S_RDHI     = 12'b0000_0001_0000,
        S_RDLO     = 12'b0000_0010_0000,
        S_INTERP   = 12'b0000_0100_0000,
        S_FIN      = 12'b0000_1000_0000,
        S_STOP     = 12'b0001_0000_0000,
        S_DIV      = 12'b0010_0000_0000,
        S_DECIDE   = 12'b0100_0000_0000,
        S_RESULT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   ch_reg, ch_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    // sequencing and commands
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd.op     = cpss_pkg::OP_NONE;
        cmd.ch     = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = cpss_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                ch_next = 1'b0;
                if (status.contact)
                    state_next = S_RESULT;
                else if (status.mode)
                    state_next = S_STOP;
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = cpss_pkg::OP_MUL;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.op     = cpss_pkg::OP_POS;
                state_next = S_RDHI;
            end
            S_RDHI:
            begin
                cmd.op     = cpss_pkg::OP_RDHI;
                state_next = S_RDLO;
            end
            S_RDLO:
            begin
                cmd.op     = cpss_pkg::OP_RDLO;
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.op     = cpss_pkg::OP_INTERP;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = cpss_pkg::OP_FIN;
                if (ch_reg)
                    state_next = S_RESULT;
                else
                begin
                    ch_next    = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_STOP:
            begin
                cmd.op     = cpss_pkg::OP_STOP;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                // run the divider only when the approach test needs the quotient
                if (status.need_div)
                    state_next = S_DIV;
                else
                    state_next = S_RESULT;
            end
            S_DIV:
            begin
                cmd.op = cpss_pkg::OP_DIV;
                if (status.div_last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = cpss_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/cpss_dp.sv
`timescale 1ns / 1ps

module cpss_dp
#(
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cpss_pkg::cfg_t      cfg,
    input  cpss_pkg::cmd_t      cmd,
    output cpss_pkg::status_t   status,
    input  logic                in_collision,
    input  logic signed [21:0]  scene_distance,
    input  logic signed [21:0]  self_distance,
    input  logic [31:0]         stop_time,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [16:0]         speed_scale,
    output logic [2:0]          cause
);

    localparam int IDXW = $clog2(EXP_TABLE_DEPTH);
    localparam int PW   = 16 + IDXW;

    typedef logic [16:0] tab_t [EXP_TABLE_DEPTH];

    // exp(-16 i / (depth-1)) in Q1.16, built with Q2.30 arithmetic
    function automatic tab_t exp_build();
        tab_t            t;
        longint unsigned N1;
        longint unsigned A;
        longint unsigned term;
        longint unsigned Sum;
        longint unsigned Step;
        longint unsigned v;
        longint unsigned K;
        N1 = longint'(EXP_TABLE_DEPTH) - 1;
        if (N1 == 0)
            N1 = 1;
        A = ((64'd16 << 30) + N1 / 2) / N1;
        term = 64'd1 << 30;
        Sum = term;
        for (K = 1; K < 48 && term != 0; K++)
        begin
            term = ((term * A) >> 30) / K;
            Sum = Sum + term;
        end
        Step = ((64'd1 << 60) + Sum / 2) / Sum;
        v = 64'd1 << 30;
        t[0] = 17'd65536;
        for (int i = 1; i < EXP_TABLE_DEPTH; i++)
        begin
            v = (v * Step + (64'd1 << 29)) >> 30;
            t[i] = 17'((v + (64'd1 << 13)) >> 14);
        end
        t[EXP_TABLE_DEPTH - 1] = 17'd0;
        return t;
    endfunction

    localparam tab_t EXP_TAB = exp_build();

    // captured item
    logic               coll_reg;
    logic signed [21:0] scene_reg;
    logic signed [21:0] self_reg;
    logic [31:0]        stop_reg;
    logic signed [21:0] last_min_reg;

    // threshold path
    logic [54:0]        u_reg;
    logic               below_reg;
    logic [15:0]        frac_reg;
    logic [IDXW-1:0]    idx_reg;
    logic               oob_reg;
    logic [16:0]        hi_reg;
    logic [16:0]        lo_reg;
    logic [32:0]        prod_reg;

    // stop path
    logic [46:0]        dvd_reg;
    logic [22:0]        dmag_reg;
    logic [23:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic [47:0]        fs_reg;
    logic               need_div_reg;

    // result
    logic [16:0]        scale_reg;
    logic [2:0]         cause_reg;
    logic               out_valid_reg;
    logic [16:0]        out_scale_reg;
    logic [2:0]         out_cause_reg;

    // operand select for the active channel
    logic signed [21:0] chan_dist;
    logic [20:0]        thr;
    logic [31:0]        gain;
    logic               below;
    logic [22:0]        gap;

    assign chan_dist = cmd.ch ? self_reg : scene_reg;
    assign thr       = cmd.ch ? cfg.self_threshold : cfg.scene_threshold;
    assign gain      = cmd.ch ? cfg.self_gain : cfg.scene_gain;
    assign below     = $signed({chan_dist[21], chan_dist}) < $signed({2'b00, thr});
    assign gap       = 23'($signed({2'b00, thr}) - $signed({chan_dist[21], chan_dist}));

    // table position
    logic [PW+7:0]      pos_full;
    logic [PW-1:0]      pos;
    logic [IDXW:0]      idx_inc;

    assign pos_full = (PW+8)'(u_reg[35:12]) * (PW+8)'(EXP_TABLE_DEPTH - 1);
    assign pos      = pos_full[PW+7:8];
    assign idx_inc  = {1'b0, pos[PW-1:16]} + 1'b1;

    // channel factor and running minimum
    logic [16:0]        factor;
    logic [16:0]        scale_min;

    always_comb
    begin
        if (!below_reg)
            factor = cpss_pkg::FULL_SCALE;
        else if (u_reg[54:36] != 19'd0 || oob_reg)
            factor = 17'd0;
        else if (lo_reg > hi_reg)
            factor = hi_reg;
        else
            factor = hi_reg - prod_reg[32:16];
        scale_min = (factor < scale_reg) ? factor : scale_reg;
    end

    // stop-distance operands
    logic signed [21:0] d;
    logic signed [22:0] delta;
    logic [21:0]        mag;
    logic               too_close;
    logic               approach;

    assign d         = (scene_reg < self_reg) ? scene_reg : self_reg;
    assign delta     = 23'($signed({d[21], d}) - $signed({last_min_reg[21], last_min_reg}));
    assign mag       = d[21] ? 22'(-$signed({d[21], d})) : 22'(d);
    assign too_close = ($signed({d[21], d}) < $signed({2'b00, cfg.min_allowed_distance}))
                       && (delta <= 0);
    assign approach  = delta[22];

    // restoring divider step
    logic [23:0]        trial;
    logic               fits;

    assign trial = {rem_reg[22:0], dvd_reg[46]};
    assign fits  = trial >= {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_min_reg  <= 22'sd0;
            need_div_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                cpss_pkg::OP_LOAD:
                begin
                    need_div_reg <= 1'b0;
                end
                cpss_pkg::OP_STOP:
                begin
                    last_min_reg <= d;
                    need_div_reg <= !too_close && approach && (stop_reg != cpss_pkg::STOP_INFINITE);
                end
                cpss_pkg::OP_DIV:
                begin
                    if (cnt_reg == cpss_pkg::DIV_LAST)
                        need_div_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == cpss_pkg::OP_OUT)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_reg <= 1'b0;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            cpss_pkg::OP_LOAD:
            begin
                coll_reg  <= in_collision;
                scene_reg <= scene_distance;
                self_reg  <= self_distance;
                stop_reg  <= stop_time;
                scale_reg <= in_collision ? 17'd0 : cpss_pkg::FULL_SCALE;
                cause_reg <= in_collision ? cpss_pkg::CAUSE_CONTACT : cpss_pkg::CAUSE_CLEAR;
            end
            cpss_pkg::OP_MUL:
            begin
                u_reg     <= 55'(gap) * 55'(gain);
                below_reg <= below;
            end
            cpss_pkg::OP_POS:
            begin
                idx_reg  <= pos[PW-1:16];
                frac_reg <= pos[15:0];
                oob_reg  <= idx_inc >= (IDXW+1)'(EXP_TABLE_DEPTH);
            end
            cpss_pkg::OP_RDHI:
            begin
                hi_reg <= EXP_TAB[idx_reg];
            end
            cpss_pkg::OP_RDLO:
            begin
                lo_reg <= oob_reg ? 17'd0 : EXP_TAB[idx_inc[IDXW-1:0]];
            end
            cpss_pkg::OP_INTERP:
            begin
                prod_reg <= 33'(hi_reg - lo_reg) * 33'(frac_reg);
            end
            cpss_pkg::OP_FIN:
            begin
                scale_reg <= scale_min;
                if (cmd.ch)
                    cause_reg <= (scale_min < cpss_pkg::FULL_SCALE) ?
                                 cpss_pkg::CAUSE_SLOWDOWN : cpss_pkg::CAUSE_CLEAR;
            end
            cpss_pkg::OP_STOP:
            begin
                dvd_reg  <= {47'(mag) * 47'(cfg.check_period)} << 8;
                dmag_reg <= 23'(-delta);
                fs_reg   <= 48'(cfg.safety_factor) * 48'(stop_reg);
                rem_reg  <= 24'd0;
                cnt_reg  <= 6'd0;
                if (too_close)
                begin
                    scale_reg <= 17'd0;
                    cause_reg <= cpss_pkg::CAUSE_TOOCLOSE;
                end
                else if (approach && stop_reg == cpss_pkg::STOP_INFINITE
                         && cfg.safety_factor != 16'd0)
                begin
                    scale_reg <= 17'd0;
                    cause_reg <= cpss_pkg::CAUSE_NOSTOP;
                end
            end
            cpss_pkg::OP_DIV:
            begin
                rem_reg <= fits ? (trial - {1'b0, dmag_reg}) : trial;
                dvd_reg <= {dvd_reg[45:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                // last quotient bit lands now; compare with it folded in
                if (cnt_reg == cpss_pkg::DIV_LAST && fs_reg > {dvd_reg[45:0], fits})
                begin
                    scale_reg <= 17'd0;
                    cause_reg <= cpss_pkg::CAUSE_NOSTOP;
                end
            end
            cpss_pkg::OP_OUT:
            begin
                out_scale_reg <= scale_reg;
                out_cause_reg <= cause_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.contact  = coll_reg;
    assign status.mode     = cfg.check_mode;
    assign status.need_div = need_div_reg;
    assign status.div_last = (cnt_reg == cpss_pkg::DIV_LAST);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign speed_scale = out_scale_reg;
    assign cause       = out_cause_reg;

    // result consistency
    a_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cause_reg == cpss_pkg::CAUSE_CONTACT |-> out_scale_reg == 17'd0)
        else $error("contact result with nonzero scale");

    a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_cause_reg == cpss_pkg::CAUSE_TOOCLOSE ||
        out_cause_reg == cpss_pkg::CAUSE_NOSTOP) |-> out_scale_reg == 17'd0)
        else $error("halt result with nonzero scale");

    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cause_reg == cpss_pkg::CAUSE_CLEAR |->
        out_scale_reg == cpss_pkg::FULL_SCALE)
        else $error("clear result below full scale");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == cpss_pkg::OP_OUT |-> !out_valid_reg || out_ready)
        else $error("result overwritten before taken");

endmodule
